// ===== sv/wgm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared constants and types for the glob wildcard matcher: pattern capacity,
// wildcard characters, item action codes and the structs that pass between
// the cells of the matching chain.
// ----------------------------------------------------------------------------
package wgm_pkg;

    // pattern capacity, one cell per stored position
    localparam int PATTERN_MAX = 64;
    localparam int CNT_W       = $clog2(PATTERN_MAX + 1);

    // wildcard characters
    localparam logic [7:0] CH_ANY_ONE = 8'h3F;   // '?'
    localparam logic [7:0] CH_ANY_RUN = 8'h2A;   // '*'

    // item action codes
    localparam logic ACT_PATTERN = 1'b0;
    localparam logic ACT_TEXT    = 1'b1;

    // broadcast to every cell
    typedef struct packed {
        logic       start;   // text item opens a new text
        logic       step;    // text item carries a character
        logic [7:0] ch;      // character of the item
    } cell_ctl_t;

    // handed from one cell to its right neighbour
    typedef struct packed {
        logic pass;          // star at an active position: next is active too
        logic fwd;           // position consumed the character
    } cell_link_t;

endpackage

`default_nettype wire

// ===== sv/wgm_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wgm_in_if
// Input channel of the matcher: pattern and text items with valid/ready.
// ----------------------------------------------------------------------------
interface wgm_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] byte_value;
    logic       has_byte;
    logic       last;

    modport source (output valid, action, byte_value, has_byte, last, input ready);
    modport sink   (input valid, action, byte_value, has_byte, last, output ready);
endinterface

`default_nettype wire

// ===== sv/wgm_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wgm_out_if
// Result channel of the matcher: one item per text, with valid/ready.
// ----------------------------------------------------------------------------
interface wgm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, matched, pattern_overflow, input ready);
    modport sink   (input valid, matched, pattern_overflow, output ready);
endinterface

`default_nettype wire

// ===== sv/wgm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wgm_cell
// One pattern position of the matching chain. Holds the pattern byte and the
// position's active bit (before star closure). Takes the link of its left
// neighbour and hands its own link to the right each cycle.
// ----------------------------------------------------------------------------
module wgm_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wgm_pkg::cell_ctl_t ctl,
    input  wire logic               wr_en,      // store ctl.ch as pattern byte
    input  wire logic               in_use,     // position lies inside the pattern
    input  wire logic               is_first,   // position 0 of the pattern
    input  wire wgm_pkg::cell_link_t left,
    output wgm_pkg::cell_link_t     right,
    output logic                    closed      // active after star closure
);

    logic [7:0] pat_reg;
    logic       act_reg;
    logic       act_next;
    logic       act_eff;
    logic       is_star;
    logic       hit;
    logic       self_keep;

    // pattern byte
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pat_reg <= ctl.ch;
        end
    end

    // a new text starts with only position 0 active
    assign act_eff = ctl.start ? is_first : act_reg;
    assign is_star = in_use && (pat_reg == wgm_pkg::CH_ANY_RUN);
    assign hit     = (pat_reg == wgm_pkg::CH_ANY_ONE) || (pat_reg == ctl.ch);

    // closure: a star on the left makes this position active too
    assign closed     = act_eff || left.pass;
    assign right.pass = act_eff && is_star;
    assign right.fwd  = closed && in_use && (is_star || hit);
    assign self_keep  = closed && is_star;

    // active bit update
    always_comb
    begin
        act_next = act_reg;
        if (ctl.step)
        begin
            act_next = left.fwd || self_keep;
        end
        else if (ctl.start)
        begin
            act_next = act_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/wildcard_glob_matcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Glob matcher ('*' any run, '?' any one character) over a chain of cells.
// ----------------------------------------------------------------------------
// Use: load a pattern on in_ch as items with action = 0, closed by last; then
// stream text items with action = 1. The last text item gives one result on
// out_ch: matched, or pattern_overflow if the pattern went beyond 64 bytes.
// An item with has_byte = 0 carries no character and gives the empty pattern
// or the empty text. A pattern item abandons any open text.
// For each text character, every cell compares its pattern byte with the
// character at once and hands its active bit to the right.
// Consecutive stars are stored once, so closure never spans more than one
// neighbour. Throughput is one item per cycle, except that after the last
// text item the input is held off until the result has moved into the output
// register: that item first sets a pending flag, and the input stays stalled
// for as long as the receiver holds a previous result.
// Reset clears the pattern length, the active bits and both handshakes; the
// matcher then holds the empty pattern. Pattern bytes need no reset.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher (
    input  wire logic clk,
    input  wire logic rst_n,
    wgm_in_if.sink    in_ch,
    wgm_out_if.source out_ch
);

    localparam int N = wgm_pkg::PATTERN_MAX;
    localparam int W = wgm_pkg::CNT_W;

    // control state
    logic [W-1:0] len_reg,  len_next;     // stored positions
    logic [W-1:0] raw_reg,  raw_next;     // bytes received, saturating
    logic         ovf_reg,  ovf_next;
    logic         load_reg, load_next;
    logic         star_reg, star_next;    // last stored byte is a star
    logic         text_reg, text_next;
    logic         pend_reg, pend_next;
    logic         tail_reg, tail_next;    // active bit of the end position
    logic         ov_reg,   ov_next;
    logic         om_reg,   om_next;
    logic         oo_reg,   oo_next;

    logic                accept;
    logic                pat_item;
    logic                txt_item;
    logic                new_pat;
    logic [W-1:0]        len_eff;
    logic [W-1:0]        raw_eff;
    logic                star_eff;
    logic                in_star;
    logic                store_byte;
    logic                load_wr;
    logic                out_free;
    logic                tail_eff;
    logic                tail_closed;
    logic                result;
    wgm_pkg::cell_ctl_t  ctl;
    wgm_pkg::cell_link_t link [0:N];
    logic [N:0]          closed;
    logic [N:0]          at_end;
    logic [N-1:0]        wr_en;
    logic [N-1:0]        in_use;

    assign accept   = in_ch.valid && in_ch.ready;
    assign pat_item = accept && (in_ch.action == wgm_pkg::ACT_PATTERN);
    assign txt_item = accept && (in_ch.action == wgm_pkg::ACT_TEXT);
    assign in_ch.ready = !pend_reg;

    // pattern loading: a fresh load restarts length, count and overflow
    assign new_pat    = pat_item && !load_reg;
    assign len_eff    = new_pat ? '0 : len_reg;
    assign raw_eff    = new_pat ? '0 : raw_reg;
    assign star_eff   = new_pat ? 1'b0 : star_reg;
    assign in_star    = (in_ch.byte_value == wgm_pkg::CH_ANY_RUN);
    assign store_byte = pat_item && in_ch.has_byte && (raw_eff < W'(N));
    assign load_wr    = store_byte && !(in_star && star_eff);

    // broadcast control
    assign ctl.start = txt_item && !text_reg;
    assign ctl.step  = txt_item && in_ch.has_byte;
    assign ctl.ch    = in_ch.byte_value;

    // per-position decode and the cell row
    assign link[0] = '0;
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        assign in_use[i] = len_reg > W'(i);
        assign at_end[i] = len_reg == W'(i);
        assign wr_en[i]  = load_wr && (len_eff == W'(i));

        wgm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .wr_en    (wr_en[i]),
            .in_use   (in_use[i]),
            .is_first (i == 0),
            .left     (link[i]),
            .right    (link[i+1]),
            .closed   (closed[i])
        );
    end

    // end position past the last cell
    assign at_end[N]   = len_reg == W'(N);
    assign tail_eff    = ctl.start ? 1'b0 : tail_reg;
    assign tail_closed = tail_eff || link[N].pass;
    assign closed[N]   = tail_closed;

    // active bit at the end of the pattern
    assign result   = |(closed & at_end);
    assign out_free = !ov_reg || out_ch.ready;

    // next state
    always_comb
    begin
        len_next  = len_reg;
        raw_next  = raw_reg;
        ovf_next  = ovf_reg;
        load_next = load_reg;
        star_next = star_reg;
        text_next = text_reg;
        pend_next = pend_reg;
        tail_next = tail_reg;

        if (pat_item)
        begin
            text_next = 1'b0;
            load_next = !in_ch.last;
            len_next  = len_eff;
            raw_next  = raw_eff;
            star_next = star_eff;
            ovf_next  = new_pat ? 1'b0 : ovf_reg;
            if (in_ch.has_byte)
            begin
                if (store_byte)
                begin
                    raw_next  = raw_eff + W'(1);
                    star_next = in_star;
                    if (load_wr)
                    begin
                        len_next = len_eff + W'(1);
                    end
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
        end

        if (txt_item)
        begin
            load_next = 1'b0;
            text_next = !in_ch.last;
            pend_next = in_ch.last;
            if (ctl.step)
            begin
                tail_next = link[N].fwd;
            end
            else if (ctl.start)
            begin
                tail_next = tail_eff;
            end
        end

        if (pend_reg && out_free)
        begin
            pend_next = 1'b0;
        end
    end

    // result register
    always_comb
    begin
        ov_next = ov_reg;
        om_next = om_reg;
        oo_next = oo_reg;
        if (out_ch.ready)
        begin
            ov_next = 1'b0;
        end
        if (pend_reg && out_free)
        begin
            ov_next = 1'b1;
            om_next = result && !ovf_reg;
            oo_next = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            raw_reg  <= '0;
            ovf_reg  <= 1'b0;
            load_reg <= 1'b0;
            star_reg <= 1'b0;
            text_reg <= 1'b0;
            pend_reg <= 1'b0;
            tail_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            raw_reg  <= raw_next;
            ovf_reg  <= ovf_next;
            load_reg <= load_next;
            star_reg <= star_next;
            text_reg <= text_next;
            pend_reg <= pend_next;
            tail_reg <= tail_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        om_reg <= om_next;
        oo_reg <= oo_next;
    end

    assign out_ch.valid            = ov_reg;
    assign out_ch.matched          = om_reg;
    assign out_ch.pattern_overflow = oo_reg;

endmodule

`default_nettype wire

// ===== dv/glob_match_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glob_match_checker
// Watches both channels of the glob matcher. Every accepted input item runs
// through an independent model of the matcher: the pattern store, the load and
// text state, and the set of live pattern positions. That model queues the
// verdict of each closed text, and each accepted result is compared with the
// oldest queued verdict.
// ----------------------------------------------------------------------------
module glob_match_checker
    import wgm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    wgm_in_if         in_ch,
    wgm_out_if        out_ch,
    output int        fail_count,
    output int        pending
);

    typedef struct packed {
        logic matched;
        logic overflow;
    } glob_verdict_t;

    // model state
    logic [7:0]         pat_mem [PATTERN_MAX];
    int                 pat_len;
    bit                 loading;
    bit                 ovf_seen;
    bit                 in_text;
    logic [PATTERN_MAX:0] live;

    glob_verdict_t      awaited_verdicts[$];

    // a star at a live position makes the next position live too (cascades)
    function automatic void spread_stars();
        for (int i = 0; i < pat_len; i++)
        begin
            if (live[i] && pat_mem[i] == CH_ANY_RUN)
                live[i + 1] = 1'b1;
        end
    endfunction

    // move every live position on by one text character
    function automatic void consume_char(input logic [7:0] c);
        logic [PATTERN_MAX:0] nxt;
        nxt = '0;
        for (int i = 0; i < pat_len; i++)
        begin
            if (live[i])
            begin
                if (pat_mem[i] == CH_ANY_RUN)
                    nxt[i] = 1'b1;
                else if (pat_mem[i] == CH_ANY_ONE || pat_mem[i] == c)
                    nxt[i + 1] = 1'b1;
            end
        end
        live = nxt;
        spread_stars();
    endfunction

    // one accepted item; a closed text queues its verdict
    function automatic void glob_step(input logic act, input logic [7:0] b,
                                      input logic hb, input logic lst);
        glob_verdict_t v;
        if (act == ACT_PATTERN)
        begin
            in_text = 1'b0;
            if (!loading)
            begin
                pat_len  = 0;
                ovf_seen = 1'b0;
                loading  = 1'b1;
            end
            if (hb)
            begin
                if (pat_len < PATTERN_MAX)
                begin
                    pat_mem[pat_len] = b;
                    pat_len++;
                end
                else
                    ovf_seen = 1'b1;
            end
            if (lst)
                loading = 1'b0;
        end
        else
        begin
            loading = 1'b0;
            if (!in_text)
            begin
                live    = '0;
                live[0] = 1'b1;
                spread_stars();
                in_text = 1'b1;
            end
            if (hb)
                consume_char(b);
            if (lst)
            begin
                in_text    = 1'b0;
                v.matched  = !ovf_seen && live[pat_len];
                v.overflow = ovf_seen;
                awaited_verdicts.push_back(v);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        glob_verdict_t exp_v;
        if (!rst_n)
        begin
            pat_len    = 0;
            loading    = 1'b0;
            ovf_seen   = 1'b0;
            in_text    = 1'b0;
            live       = '0;
            awaited_verdicts.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                glob_step(in_ch.action, in_ch.byte_value, in_ch.has_byte, in_ch.last);

            if (out_ch.valid && out_ch.ready)
            begin
                if (awaited_verdicts.size() == 0)
                begin
                    $error("unexpected result: matched %0b pattern_overflow %0b",
                           out_ch.matched, out_ch.pattern_overflow);
                    fail_count++;
                end
                else
                begin
                    exp_v = awaited_verdicts.pop_front();
                    if (out_ch.matched !== exp_v.matched)
                    begin
                        $error("matched: expected %0b, actual %0b",
                               exp_v.matched, out_ch.matched);
                        fail_count++;
                    end
                    if (out_ch.pattern_overflow !== exp_v.overflow)
                    begin
                        $error("pattern_overflow: expected %0b, actual %0b",
                               exp_v.overflow, out_ch.pattern_overflow);
                        fail_count++;
                    end
                end
            end
            pending = awaited_verdicts.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives patterns and texts into the glob matcher with random gaps on both
// sides: a short directed run over the corner cases, then random groups of
// one pattern and up to four texts, most of them derived from the pattern so
// that matches are common. The checker beside the block keeps the score.
// ----------------------------------------------------------------------------
module tb_top;
    import wgm_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 300000;

    // plain text characters
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_C = 8'h63;

    typedef logic [7:0] byte_q_t[$];

    logic        clk = 1'b0;
    logic        rst_n;
    bit          tx_idle;
    bit          rx_idle;
    bit          hold_req;
    int          items_sent;
    int          fail_count;
    int          pending;
    int unsigned cycles;

    wgm_in_if  in_ch ();
    wgm_out_if out_ch ();

    wildcard_glob_matcher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    glob_match_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #4 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // one item, after a random gap; returns at the falling edge after acceptance
    task automatic put_item(input logic act, input logic [7:0] b,
                            input logic hb, input logic lst);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.action     <= act;
        in_ch.byte_value <= b;
        in_ch.has_byte   <= hb;
        in_ch.last       <= lst;
        in_ch.valid      <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // whole pattern or text; empty gives a lone marker, stray markers now and then
    task automatic put_seq(input logic act, input byte_q_t bytes, input bit close);
        int n;
        n = bytes.size();
        if (n == 0)
        begin
            put_item(act, 8'($urandom_range(0, 255)), 1'b0, close);
            return;
        end
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                put_item(act, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            put_item(act, bytes[i], 1'b1, close && i == n - 1);
        end
    endtask

    // sender waits until every queued verdict has been delivered
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    function automatic logic [7:0] pattern_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return CH_A;
            3, 4:    return CH_B;
            5, 6:    return CH_ANY_RUN;
            7:       return CH_ANY_ONE;
            8:       return CH_C;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] text_char();
        case ($urandom_range(0, 5))
            0, 1:    return CH_A;
            2, 3:    return CH_B;
            4:       return CH_C;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic byte_q_t make_pattern();
        byte_q_t p;
        int len;
        // mostly short; now and then around the capacity edge
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(PATTERN_MAX - 4, PATTERN_MAX + 6)
                                           : $urandom_range(0, 8);
        for (int i = 0; i < len; i++)
            p.push_back(pattern_char());
        return p;
    endfunction

    // text built to fit the pattern, then sometimes spoilt by one edit
    function automatic byte_q_t make_text(input byte_q_t pat);
        byte_q_t t;
        int idx;
        if ($urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(0, 6))
                t.push_back(text_char());
            return t;
        end
        foreach (pat[i])
        begin
            if (pat[i] == CH_ANY_RUN)
            begin
                repeat ($urandom_range(0, 3))
                    t.push_back(text_char());
            end
            else if (pat[i] == CH_ANY_ONE)
                t.push_back(text_char());
            else
                t.push_back(pat[i]);
        end
        idx = $urandom_range(0, t.size());
        case ($urandom_range(0, 5))
            0: if (idx < t.size()) t[idx] = text_char();
            1: if (idx < t.size()) t.delete(idx);
            2: t.insert(idx, text_char());
            default: ;
        endcase
        return t;
    endfunction

    // result receiver: random stall per result, one long hold on request
    initial
    begin : result_sink
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            stall = rx_idle ? $urandom_range(0, 9) : 0;
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid && !hold_req)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        byte_q_t pat;
        byte_q_t txt;
        int      n_text;
        bit      hold_done;

        in_ch.valid      = 1'b0;
        in_ch.action     = ACT_PATTERN;
        in_ch.byte_value = 8'h00;
        in_ch.has_byte   = 1'b0;
        in_ch.last       = 1'b0;
        rst_n            = 1'b0;
        tx_idle          = 1'b1;
        rx_idle          = 1'b1;
        hold_req         = 1'b0;
        hold_done        = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // nothing loaded: only the empty text matches
        put_item(ACT_TEXT, 8'h00, 1'b0, 1'b1);
        put_item(ACT_TEXT, CH_A, 1'b1, 1'b1);
        // empty pattern against the empty text
        put_item(ACT_PATTERN, 8'hFF, 1'b0, 1'b1);
        put_item(ACT_TEXT, 8'hFF, 1'b0, 1'b1);
        // lone star swallows anything, nothing included
        put_item(ACT_PATTERN, CH_ANY_RUN, 1'b1, 1'b1);
        put_item(ACT_TEXT, 8'h00, 1'b0, 1'b1);
        put_item(ACT_TEXT, 8'h00, 1'b1, 1'b0);
        put_item(ACT_TEXT, 8'hFF, 1'b1, 1'b1);
        // byte extremes round a single-character wildcard
        put_item(ACT_PATTERN, 8'h00, 1'b1, 1'b0);
        put_item(ACT_PATTERN, CH_ANY_ONE, 1'b1, 1'b0);
        put_item(ACT_PATTERN, 8'hFF, 1'b1, 1'b1);
        put_item(ACT_TEXT, 8'h00, 1'b1, 1'b0);
        put_item(ACT_TEXT, CH_A, 1'b1, 1'b0);
        put_item(ACT_TEXT, 8'hFF, 1'b1, 1'b1);
        put_item(ACT_TEXT, 8'h00, 1'b1, 1'b0);
        put_item(ACT_TEXT, 8'hFF, 1'b1, 1'b1);
        // doubled star ahead of a literal
        put_item(ACT_PATTERN, CH_ANY_RUN, 1'b1, 1'b0);
        put_item(ACT_PATTERN, CH_ANY_RUN, 1'b1, 1'b0);
        put_item(ACT_PATTERN, CH_B, 1'b1, 1'b1);
        put_item(ACT_TEXT, CH_B, 1'b1, 1'b1);
        // text cuts the load short; pattern holds what came so far
        put_item(ACT_PATTERN, CH_A, 1'b1, 1'b0);
        put_item(ACT_PATTERN, CH_B, 1'b1, 1'b0);
        put_item(ACT_TEXT, CH_A, 1'b1, 1'b0);
        put_item(ACT_TEXT, CH_B, 1'b1, 1'b1);
        // open text dropped by a new pattern
        put_item(ACT_TEXT, CH_A, 1'b1, 1'b0);
        put_item(ACT_PATTERN, CH_A, 1'b1, 1'b1);
        put_item(ACT_TEXT, CH_A, 1'b1, 1'b1);
        wait_for_results();

        // random groups: a pattern, then up to four texts
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            pat = make_pattern();
            put_seq(ACT_PATTERN, pat, $urandom_range(0, 9) != 0);
            n_text = $urandom_range(0, 4);
            for (int k = 0; k < n_text; k++)
            begin
                txt = make_text(pat);
                put_seq(ACT_TEXT, txt, $urandom_range(0, 9) != 0);
            end
            if (!hold_done && items_sent > RANDOM_ITEMS / 3)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 7) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
